@@ rtl/core/i8080s_pkg.sv @@
// Shared types, codes and helpers for the 8080 subset core.
`default_nettype none
package i8080s_pkg;

   typedef enum logic [2:0] {
      KIND_MEM_RD   = 3'd0,
      KIND_MEM_WR   = 3'd1,
      KIND_PORT_RD  = 3'd2,
      KIND_PORT_WR  = 3'd3,
      KIND_DONE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_MEM   = 2'd1,
      FUNC_PORT  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_OPCODE = 3'd1,
      PH_OPND1  = 3'd2,
      PH_OPND2  = 3'd3,
      PH_MEM    = 3'd4,
      PH_RETHI  = 3'd5,
      PH_PORT   = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [4:0]  cyc;
      logic        uns;
   } item_type;

   localparam logic [15:0] SP_RESET = 16'h2400;

   localparam logic [2:0] FLAG_Z = 3'b010;

   function automatic item_type mk_item(kind_type k, logic [15:0] a, logic [7:0] d,
                                        logic [4:0] c, logic u);
      item_type it;
      it.kind = k; it.addr = a; it.data = d; it.cyc = c; it.uns = u;
      return it;
   endfunction

   function automatic item_type done_item(logic [4:0] c);
      return mk_item(KIND_DONE, 16'h0000, 8'h00, c, 1'b0);
   endfunction

   function automatic logic word_opnd(logic [7:0] op);
      case (op)
         8'h01, 8'h11, 8'h21, 8'h31, 8'h32, 8'h3A,
         8'hC2, 8'hC3, 8'hCA, 8'hCD: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic byte_opnd(logic [7:0] op);
      return ((op & 8'hC7) == 8'h06) || op == 8'hC6 || op == 8'hD6 ||
             op == 8'hFE || op == 8'hD3 || op == 8'hDB;
   endfunction

   function automatic logic is_alu(logic [7:0] op);
      logic [7:0] g;
      g = op & 8'hF8;
      return g == 8'h80 || g == 8'h90 || g == 8'hA0 || (g == 8'hB0 && op != 8'hB7);
   endfunction

   // keep carry, set zero and sign from the byte
   function automatic logic [2:0] zs(logic [2:0] f, logic [7:0] v);
      return {v[7], v == 8'h00, f[0]};
   endfunction

   // ALU group result: {flags, acc}; bits 5:4 pick ADD, SUB, ANA, ORA
   function automatic logic [10:0] alu(logic [7:0] op, logic [7:0] a, logic [7:0] v);
      logic [8:0] s;
      logic [7:0] r;
      logic       c;
      s = 9'd0;
      case (op[5:4])
         2'd0: begin s = {1'b0, a} + {1'b0, v}; r = s[7:0]; c = s[8]; end
         2'd1: begin r = a - v; c = a < v; end
         2'd2: begin r = a & v; c = 1'b0; end
         default: begin r = a | v; c = 1'b0; end
      endcase
      return {r[7], r == 8'h00, c, r};
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/i8080s_outq.sv @@
// Result queue: up to three items in at once, one out per cycle unless stalled.
`default_nettype none
module i8080s_outq
   import i8080s_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire logic [1:0] push_n,
   input  wire item_type push_item [3],
   output logic          room,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   output item_type      rsp_item,
   output logic          rsp_last
);
   localparam int unsigned DEPTH = 8;

   item_type  mem_ff [DEPTH];
   logic      last_ff [DEPTH];
   logic [2:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != 4'd0;
   assign rsp_item   = mem_ff[rd_ff];
   assign rsp_last   = last_ff[rd_ff];
   // room for a full burst of three
   assign room       = cnt_ff <= 4'd5;

   always_comb begin
      wr_in  = push ? wr_ff + {1'b0, push_n} : wr_ff;
      rd_in  = pop ? rd_ff + 3'd1 : rd_ff;
      cnt_in = cnt_ff + (push ? {2'b00, push_n} : 4'd0) - {3'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_n) begin
               mem_ff[3'(wr_ff + 3'(i))]  <= push_item[i];
               last_ff[3'(wr_ff + 3'(i))] <= (2'(i + 1) == push_n);
            end
         end
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 4'd8)
      else $error("queue overflow");
   a_valid_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid == (cnt_ff != 4'd0)) else $error("valid mismatch");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> room) else $error("push without room");

endmodule
`default_nettype wire

@@ rtl/core/i8080_subset_core.sv @@
// Top level of the 8080 subset core: request decode, state and result queue.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata[7:0] read_data, tuser[1:0] func
//  rsp     | out | rsp_tvalid/tready   | tdata[31:0], tuser[0] unsupported_seen, tlast
//
// Each accepted item is decoded and executed in the cycle it arrives; its
// zero to three result items land in an eight-entry queue and leave one per
// cycle. req_tready drops only while the queue lacks room for three more
// items. Reset is synchronous and clears all architectural state, SP to 2400h.
// A stalled result side backs up the queue and then stalls the input.
`default_nettype none
module i8080_subset_core
   import i8080s_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] read_data
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [2:0] request_kind, [18:3] bus_address,
                                         // [26:19] bus_data, [31:27] cycle_count
   output logic             rsp_tuser,   // [0] unsupported_seen
   output logic             rsp_tlast
);

   logic [7:0]  a_ff, a_in;
   logic [7:0]  r_ff [6];
   logic [7:0]  r_in [6];
   logic [2:0]  f_ff, f_in;
   logic [15:0] pc_ff, pc_in, sp_ff, sp_in;
   logic        halt_ff, halt_in;
   logic [31:0] ucnt_ff, ucnt_in;
   phase_type   ph_ff, ph_in;
   logic [7:0]  op_ff, op_in, lo_ff, lo_in;

   logic        acc, room, push;
   logic [1:0]  n;
   item_type    it [3];
   item_type    q_item;

   logic [7:0]  d, op;
   logic [15:0] hl, w;
   logic [10:0] ar;

   assign req_tready = room;
   assign acc        = req_tvalid && req_tready;
   assign d          = req_tdata;
   assign op         = op_ff;
   assign hl         = {r_ff[4], r_ff[5]};
   assign w          = {d, lo_ff};

   function automatic logic [7:0] rd(logic [2:0] i, logic [7:0] a,
                                     logic [7:0] b, logic [7:0] c, logic [7:0] dd,
                                     logic [7:0] e, logic [7:0] h, logic [7:0] l);
      case (i)
         3'd0: return b;
         3'd1: return c;
         3'd2: return dd;
         3'd3: return e;
         3'd4: return h;
         3'd5: return l;
         3'd7: return a;
         default: return 8'h00;
      endcase
   endfunction

   always_comb begin
      logic [7:0]  src;
      logic [15:0] t;
      a_in = a_ff; r_in = r_ff; f_in = f_ff; pc_in = pc_ff; sp_in = sp_ff;
      halt_in = halt_ff; ucnt_in = ucnt_ff; ph_in = ph_ff; op_in = op_ff; lo_in = lo_ff;
      n = 2'd0;
      it[0] = done_item(5'd0); it[1] = done_item(5'd0); it[2] = done_item(5'd0);
      ar = 11'd0; src = 8'd0; t = 16'd0;
      case (func_type'(req_tuser))
         FUNC_START: begin
            if (ph_ff == PH_IDLE) begin
               n = 2'd1;
               if (halt_ff) it[0] = done_item(5'd4);
               else begin
                  it[0] = mk_item(KIND_MEM_RD, pc_ff, 8'h00, 5'd0, 1'b0);
                  pc_in = pc_ff + 16'd1; ph_in = PH_OPCODE;
               end
            end
         end
         FUNC_MEM: begin
            case (ph_ff)
               PH_OPCODE: begin
                  op_in = d;
                  src = rd(d[2:0], a_ff, r_ff[0], r_ff[1], r_ff[2], r_ff[3], r_ff[4], r_ff[5]);
                  ar = alu(d, a_ff, src);
                  if (d[7:6] == 2'b01 && d != 8'h76) begin
                     if (d[2:0] == 3'd6) begin
                        n = 2'd1; it[0] = mk_item(KIND_MEM_RD, hl, 8'h00, 5'd0, 1'b0);
                        ph_in = PH_MEM;
                     end else if (d[5:3] == 3'd6) begin
                        n = 2'd2; it[0] = mk_item(KIND_MEM_WR, hl, src, 5'd0, 1'b0);
                        it[1] = done_item(5'd7); ph_in = PH_IDLE;
                     end else begin
                        if (d[5:3] == 3'd7) a_in = src;
                        else r_in[d[5:3]] = src;
                        n = 2'd1; it[0] = done_item(5'd5); ph_in = PH_IDLE;
                     end
                  end else if (word_opnd(d) || byte_opnd(d)) begin
                     n = 2'd1; it[0] = mk_item(KIND_MEM_RD, pc_ff, 8'h00, 5'd0, 1'b0);
                     pc_in = pc_ff + 16'd1; ph_in = PH_OPND1;
                  end else if (is_alu(d)) begin
                     n = 2'd1;
                     if (d[2:0] == 3'd6) begin
                        it[0] = mk_item(KIND_MEM_RD, hl, 8'h00, 5'd0, 1'b0); ph_in = PH_MEM;
                     end else begin
                        a_in = ar[7:0]; f_in = ar[10:8];
                        it[0] = done_item(5'd4); ph_in = PH_IDLE;
                     end
                  end else begin
                     n = 2'd1; ph_in = PH_IDLE;
                     case (d)
                        8'h00, 8'hF3, 8'hFB: it[0] = done_item(5'd4);
                        8'h23: begin
                           t = hl + 16'd1; r_in[4] = t[15:8]; r_in[5] = t[7:0];
                           it[0] = done_item(5'd5);
                        end
                        8'h3C: begin
                           a_in = a_ff + 8'd1; f_in = zs(f_ff, a_ff + 8'd1);
                           it[0] = done_item(5'd5);
                        end
                        8'h3D: begin
                           a_in = a_ff - 8'd1; f_in = zs(f_ff, a_ff - 8'd1);
                           it[0] = done_item(5'd5);
                        end
                        8'h76: begin halt_in = 1'b1; it[0] = done_item(5'd7); end
                        8'hAF: begin a_in = 8'h00; f_in = FLAG_Z; it[0] = done_item(5'd4); end
                        8'hB7: begin f_in = zs(f_ff, a_ff); it[0] = done_item(5'd4); end
                        8'hC9: begin
                           it[0] = mk_item(KIND_MEM_RD, sp_ff, 8'h00, 5'd0, 1'b0);
                           ph_in = PH_MEM;
                        end
                        default: begin
                           ucnt_in = ucnt_ff + 32'd1;
                           it[0] = mk_item(KIND_DONE, 16'h0000, 8'h00, 5'd4, 1'b1);
                        end
                     endcase
                  end
               end
               PH_OPND1: begin
                  lo_in = d; n = 2'd1; ph_in = PH_IDLE;
                  if (word_opnd(op)) begin
                     it[0] = mk_item(KIND_MEM_RD, pc_ff, 8'h00, 5'd0, 1'b0);
                     pc_in = pc_ff + 16'd1; ph_in = PH_OPND2;
                  end else if ((op & 8'hC7) == 8'h06) begin
                     if (op[5:3] == 3'd6) begin
                        n = 2'd2; it[0] = mk_item(KIND_MEM_WR, hl, d, 5'd0, 1'b0);
                        it[1] = done_item(5'd10);
                     end else begin
                        if (op[5:3] == 3'd7) a_in = d;
                        else r_in[op[5:3]] = d;
                        it[0] = done_item(5'd7);
                     end
                  end else begin
                     case (op)
                        8'hC6, 8'hD6: begin
                           ar = alu(op, a_ff, d); a_in = ar[7:0]; f_in = ar[10:8];
                           it[0] = done_item(5'd7);
                        end
                        8'hFE: begin
                           ar = alu(8'h90, a_ff, d); f_in = ar[10:8];
                           it[0] = done_item(5'd7);
                        end
                        8'hD3: begin
                           n = 2'd2;
                           it[0] = mk_item(KIND_PORT_WR, {8'h00, d}, a_ff, 5'd0, 1'b0);
                           it[1] = done_item(5'd10);
                        end
                        default: begin
                           it[0] = mk_item(KIND_PORT_RD, {8'h00, d}, 8'h00, 5'd0, 1'b0);
                           ph_in = PH_PORT;
                        end
                     endcase
                  end
               end
               PH_OPND2: begin
                  n = 2'd1; ph_in = PH_IDLE; it[0] = done_item(5'd10);
                  case (op)
                     8'h01: begin r_in[1] = lo_ff; r_in[0] = d; end
                     8'h11: begin r_in[3] = lo_ff; r_in[2] = d; end
                     8'h21: begin r_in[5] = lo_ff; r_in[4] = d; end
                     8'h31: sp_in = w;
                     8'h32: begin
                        n = 2'd2; it[0] = mk_item(KIND_MEM_WR, w, a_ff, 5'd0, 1'b0);
                        it[1] = done_item(5'd13);
                     end
                     8'h3A: begin
                        it[0] = mk_item(KIND_MEM_RD, w, 8'h00, 5'd0, 1'b0); ph_in = PH_MEM;
                     end
                     8'hC2: if (!f_ff[1]) pc_in = w;
                     8'hCA: if (f_ff[1]) pc_in = w;
                     8'hC3: pc_in = w;
                     default: begin
                        t = sp_ff - 16'd2; sp_in = t; n = 2'd3;
                        it[0] = mk_item(KIND_MEM_WR, t, pc_ff[7:0], 5'd0, 1'b0);
                        it[1] = mk_item(KIND_MEM_WR, sp_ff - 16'd1, pc_ff[15:8], 5'd0, 1'b0);
                        it[2] = done_item(5'd17); pc_in = w;
                     end
                  endcase
               end
               PH_MEM: begin
                  n = 2'd1; ph_in = PH_IDLE;
                  if (op[7:6] == 2'b01) begin
                     if (op[5:3] == 3'd7) a_in = d;
                     else if (op[5:3] != 3'd6) r_in[op[5:3]] = d;
                     it[0] = done_item(5'd7);
                  end else if (op == 8'h3A) begin
                     a_in = d; f_in = zs(f_ff, d); it[0] = done_item(5'd13);
                  end else if (op == 8'hC9) begin
                     lo_in = d; ph_in = PH_RETHI;
                     it[0] = mk_item(KIND_MEM_RD, sp_ff + 16'd1, 8'h00, 5'd0, 1'b0);
                  end else begin
                     ar = alu(op, a_ff, d); a_in = ar[7:0]; f_in = ar[10:8];
                     it[0] = done_item(5'd7);
                  end
               end
               PH_RETHI: begin
                  pc_in = w; sp_in = sp_ff + 16'd2; ph_in = PH_IDLE;
                  n = 2'd1; it[0] = done_item(5'd10);
               end
               default: ;
            endcase
         end
         FUNC_PORT: begin
            if (ph_ff == PH_PORT) begin
               a_in = d; f_in = zs(f_ff, d); ph_in = PH_IDLE;
               n = 2'd1; it[0] = done_item(5'd10);
            end
         end
         default: ;
      endcase
   end

   assign push = acc && n != 2'd0;

   // hold architectural state; advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; f_ff <= '0; pc_ff <= '0; sp_ff <= SP_RESET;
         halt_ff <= 1'b0; ucnt_ff <= '0; ph_ff <= PH_IDLE;
         for (int i = 0; i < 6; i++) r_ff[i] <= '0;
      end else if (acc) begin
         a_ff <= a_in; f_ff <= f_in; pc_ff <= pc_in; sp_ff <= sp_in;
         halt_ff <= halt_in; ucnt_ff <= ucnt_in; ph_ff <= ph_in;
         r_ff <= r_in;
      end
      if (acc) begin
         op_ff <= op_in; lo_ff <= lo_in;
      end
   end

   i8080s_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_n     (n),
      .push_item  (it),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (q_item),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {q_item.cyc, q_item.data, q_item.addr, q_item.kind};
   assign rsp_tuser = q_item.uns;

   a_halt_stays: assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) && !$past(reset) |-> halt_ff) else $error("halt cleared");
   a_idle_on_halt: assert property (@(posedge clock) disable iff (reset)
      $rose(halt_ff) |-> ph_ff == PH_IDLE) else $error("halt mid instruction");
   a_ucnt_step: assert property (@(posedge clock) disable iff (reset)
      !acc |=> $stable(ucnt_ff)) else $error("counter moved without item");

endmodule
`default_nettype wire

@@ tb/tb_i8080_subset_core.sv @@
// Self-checking testbench for the 8080 subset core's bus request channel.
`timescale 1ns / 100ps
`default_nettype none
module tb_i8080_subset_core;
   import i8080s_pkg::*;

   // One bus request or done item as the core should emit it.
   typedef struct {
      kind_type   kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [4:0]  cyc;
      logic        uns;
      logic        last;
   } bus_req_type;

   // One row of the directed table: input item plus an optional typed-in answer.
   typedef struct {
      func_type    fn;
      logic [7:0]  byte_in;
      logic        typed;
      kind_type    exp_kind;
      logic [4:0]  exp_cyc;
      logic        exp_uns;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] read_data
   logic [1:0]  req_tuser;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [2:0] kind, [18:3] address, [26:19] data, [31:27] cycles
   logic        rsp_tuser;    // [0] unsupported_seen
   logic        rsp_tlast;

   i8080_subset_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Predictor copy of the architectural state.
   logic [7:0]  acc_q;
   logic [7:0]  gpr_q [6];
   logic [2:0]  flags_q;
   logic [15:0] pc_q;
   logic [15:0] sp_q;
   logic        halted_q;
   logic [31:0] bad_op_count;
   phase_type   phase_q;
   logic [7:0]  op_q;
   logic [7:0]  lo_q;

   bus_req_type bus_expected [$];
   bus_req_type new_reqs [$];
   int          mismatches;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   bit          hold_off;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous ceiling for every item, even at 76 % stall and with the long hold-off.
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic emit_req(input kind_type k, input logic [15:0] a, input logic [7:0] d,
                           input logic [4:0] c, input logic u);
      bus_req_type r;
      r.kind = k; r.addr = a; r.data = d; r.cyc = c; r.uns = u; r.last = 1'b0;
      new_reqs.push_back(r);
   endtask

   task automatic emit_done(input logic [4:0] c);
      emit_req(KIND_DONE, 16'h0000, 8'h00, c, 1'b0);
      phase_q = PH_IDLE;
   endtask

   function automatic logic [15:0] hl_pair();
      return {gpr_q[4], gpr_q[5]};
   endfunction

   function automatic logic [7:0] reg_read(input logic [2:0] idx);
      if (idx == 3'd7) return acc_q;
      if (idx < 3'd6) return gpr_q[idx];
      return 8'h00;
   endfunction

   task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
      if (idx == 3'd7) acc_q = v;
      else if (idx < 3'd6) gpr_q[idx] = v;
   endtask

   // Zero and sign follow the byte; carry is kept.
   task automatic set_zs(input logic [7:0] v);
      flags_q = {v[7], v == 8'h00, flags_q[0]};
   endtask

   function automatic bit has_word(input logic [7:0] op);
      return op inside {8'h01, 8'h11, 8'h21, 8'h31, 8'h32, 8'h3A,
                        8'hC2, 8'hC3, 8'hCA, 8'hCD};
   endfunction

   function automatic bit has_byte(input logic [7:0] op);
      return (op & 8'hC7) == 8'h06 || op inside {8'hC6, 8'hD6, 8'hFE, 8'hD3, 8'hDB};
   endfunction

   function automatic bit alu_group(input logic [7:0] op);
      logic [7:0] g;
      g = op & 8'hF8;
      return g == 8'h80 || g == 8'h90 || g == 8'hA0 || (g == 8'hB0 && op != 8'hB7);
   endfunction

   // ADD, SUB, ANA, ORA by bits 5:4 of the opcode.
   task automatic run_alu(input logic [7:0] op, input logic [7:0] v);
      logic [8:0] s;
      s = {1'b0, acc_q} + {1'b0, v};
      case (op[5:4])
         2'd0: begin acc_q = s[7:0]; flags_q = {2'b00, s[8]}; end
         2'd1: begin flags_q = {2'b00, acc_q < v}; acc_q = acc_q - v; end
         2'd2: begin acc_q = acc_q & v; flags_q = 3'b000; end
         default: begin acc_q = acc_q | v; flags_q = 3'b000; end
      endcase
      set_zs(acc_q);
   endtask

   task automatic fetch_byte(input phase_type nxt);
      emit_req(KIND_MEM_RD, pc_q, 8'h00, 5'd0, 1'b0);
      pc_q = pc_q + 16'd1;
      phase_q = nxt;
   endtask

   task automatic decode_opcode(input logic [7:0] op);
      op_q = op;
      if (op[7:6] == 2'b01 && op != 8'h76) begin
         if (op[2:0] == 3'd6) begin
            emit_req(KIND_MEM_RD, hl_pair(), 8'h00, 5'd0, 1'b0);
            phase_q = PH_MEM;
         end else if (op[5:3] == 3'd6) begin
            emit_req(KIND_MEM_WR, hl_pair(), reg_read(op[2:0]), 5'd0, 1'b0);
            emit_done(5'd7);
         end else begin
            reg_write(op[5:3], reg_read(op[2:0]));
            emit_done(5'd5);
         end
      end else if (has_word(op) || has_byte(op)) begin
         fetch_byte(PH_OPND1);
      end else if (alu_group(op)) begin
         if (op[2:0] == 3'd6) begin
            emit_req(KIND_MEM_RD, hl_pair(), 8'h00, 5'd0, 1'b0);
            phase_q = PH_MEM;
         end else begin
            run_alu(op, reg_read(op[2:0]));
            emit_done(5'd4);
         end
      end else begin
         case (op)
            8'h00, 8'hF3, 8'hFB: emit_done(5'd4);
            8'h23: begin
               {gpr_q[4], gpr_q[5]} = hl_pair() + 16'd1;
               emit_done(5'd5);
            end
            8'h3C: begin acc_q = acc_q + 8'd1; set_zs(acc_q); emit_done(5'd5); end
            8'h3D: begin acc_q = acc_q - 8'd1; set_zs(acc_q); emit_done(5'd5); end
            8'h76: begin halted_q = 1'b1; emit_done(5'd7); end
            8'hAF: begin acc_q = 8'h00; flags_q = 3'b010; emit_done(5'd4); end
            8'hB7: begin set_zs(acc_q); emit_done(5'd4); end
            8'hC9: begin
               emit_req(KIND_MEM_RD, sp_q, 8'h00, 5'd0, 1'b0);
               phase_q = PH_MEM;
            end
            default: begin
               bad_op_count = bad_op_count + 32'd1;
               emit_req(KIND_DONE, 16'h0000, 8'h00, 5'd4, 1'b1);
               phase_q = PH_IDLE;
            end
         endcase
      end
   endtask

   task automatic first_operand(input logic [7:0] d);
      logic [7:0] r;
      lo_q = d;
      if (has_word(op_q)) begin
         fetch_byte(PH_OPND2);
      end else if ((op_q & 8'hC7) == 8'h06) begin
         if (op_q[5:3] == 3'd6) begin
            emit_req(KIND_MEM_WR, hl_pair(), d, 5'd0, 1'b0);
            emit_done(5'd10);
         end else begin
            reg_write(op_q[5:3], d);
            emit_done(5'd7);
         end
      end else begin
         case (op_q)
            8'hC6: begin run_alu(8'h80, d); emit_done(5'd7); end
            8'hD6: begin run_alu(8'h90, d); emit_done(5'd7); end
            8'hFE: begin
               r = acc_q - d;
               flags_q = {r[7], r == 8'h00, acc_q < d};
               emit_done(5'd7);
            end
            8'hD3: begin
               emit_req(KIND_PORT_WR, {8'h00, d}, acc_q, 5'd0, 1'b0);
               emit_done(5'd10);
            end
            default: begin
               emit_req(KIND_PORT_RD, {8'h00, d}, 8'h00, 5'd0, 1'b0);
               phase_q = PH_PORT;
            end
         endcase
      end
   endtask

   task automatic second_operand(input logic [7:0] d);
      logic [15:0] w;
      w = {d, lo_q};
      case (op_q)
         8'h01: begin gpr_q[1] = lo_q; gpr_q[0] = d; emit_done(5'd10); end
         8'h11: begin gpr_q[3] = lo_q; gpr_q[2] = d; emit_done(5'd10); end
         8'h21: begin gpr_q[5] = lo_q; gpr_q[4] = d; emit_done(5'd10); end
         8'h31: begin sp_q = w; emit_done(5'd10); end
         8'h32: begin
            emit_req(KIND_MEM_WR, w, acc_q, 5'd0, 1'b0);
            emit_done(5'd13);
         end
         8'h3A: begin
            emit_req(KIND_MEM_RD, w, 8'h00, 5'd0, 1'b0);
            phase_q = PH_MEM;
         end
         8'hC2: begin if (!flags_q[1]) pc_q = w; emit_done(5'd10); end
         8'hCA: begin if (flags_q[1]) pc_q = w; emit_done(5'd10); end
         8'hC3: begin pc_q = w; emit_done(5'd10); end
         default: begin
            // CALL: push return address low byte first, then jump
            sp_q = sp_q - 16'd2;
            emit_req(KIND_MEM_WR, sp_q, pc_q[7:0], 5'd0, 1'b0);
            emit_req(KIND_MEM_WR, sp_q + 16'd1, pc_q[15:8], 5'd0, 1'b0);
            pc_q = w;
            emit_done(5'd17);
         end
      endcase
   endtask

   task automatic memory_answer(input logic [7:0] d);
      if (op_q[7:6] == 2'b01) begin
         reg_write(op_q[5:3], d);
         emit_done(5'd7);
      end else if (op_q == 8'h3A) begin
         acc_q = d; set_zs(d); emit_done(5'd13);
      end else if (op_q == 8'hC9) begin
         lo_q = d;
         emit_req(KIND_MEM_RD, sp_q + 16'd1, 8'h00, 5'd0, 1'b0);
         phase_q = PH_RETHI;
      end else begin
         run_alu(op_q, d);
         emit_done(5'd7);
      end
   endtask

   // Work out the bus requests caused by one accepted item.
   task automatic predict_bus_reqs(input func_type fn, input logic [7:0] d);
      new_reqs.delete();
      case (fn)
         FUNC_START: if (phase_q == PH_IDLE) begin
            if (halted_q) emit_req(KIND_DONE, 16'h0000, 8'h00, 5'd4, 1'b0);
            else fetch_byte(PH_OPCODE);
         end
         FUNC_MEM: case (phase_q)
            PH_OPCODE: decode_opcode(d);
            PH_OPND1:  first_operand(d);
            PH_OPND2:  second_operand(d);
            PH_MEM:    memory_answer(d);
            PH_RETHI: begin
               pc_q = {d, lo_q};
               sp_q = sp_q + 16'd2;
               emit_done(5'd10);
            end
            default: ;
         endcase
         FUNC_PORT: if (phase_q == PH_PORT) begin
            acc_q = d; set_zs(d); emit_done(5'd10);
         end
         default: ;
      endcase
      if (new_reqs.size() > 0) new_reqs[new_reqs.size() - 1].last = 1'b1;
   endtask

   // Offer one item, hold it until accepted, then predict. Valid drops only while idling.
   task automatic send_item(input func_type fn, input logic [7:0] d);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      predict_bus_reqs(fn, d);
      foreach (new_reqs[i]) bus_expected.push_back(new_reqs[i]);
   endtask

   // Run one instruction through the channel, answering each request and now and then poking a stray item.
   task automatic run_instruction(input logic [7:0] op);
      int guard;
      send_item(FUNC_START, 8'($urandom_range(255, 0)));
      if (phase_q != PH_OPCODE) return;
      send_item(FUNC_MEM, op);
      guard = 0;
      while (phase_q != PH_IDLE && guard < 4) begin
         // occasionally poke a stray answer or a start that must be ignored
         if ($urandom_range(15, 0) == 0)
            send_item(phase_q == PH_PORT ? FUNC_MEM : FUNC_PORT, 8'($urandom_range(255, 0)));
         if ($urandom_range(31, 0) == 0)
            send_item(FUNC_START, 8'($urandom_range(255, 0)));
         send_item(phase_q == PH_PORT ? FUNC_PORT : FUNC_MEM, 8'($urandom_range(255, 0)));
         guard++;
      end
   endtask

   // Result checker: compare each accepted item with the oldest expectation.
   always @(posedge clock) begin
      bus_req_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bus_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected item tdata=%h", rsp_tdata));
         end else begin
            e = bus_expected.pop_front();
            if (rsp_tdata[2:0] !== e.kind)
               report_mismatch($sformatf("kind %0d want %0d", rsp_tdata[2:0], e.kind));
            if (rsp_tdata[18:3] !== e.addr)
               report_mismatch($sformatf("address %h want %h", rsp_tdata[18:3], e.addr));
            if (rsp_tdata[26:19] !== e.data)
               report_mismatch($sformatf("data %h want %h", rsp_tdata[26:19], e.data));
            if (rsp_tdata[31:27] !== e.cyc)
               report_mismatch($sformatf("cycles %0d want %0d", rsp_tdata[31:27], e.cyc));
            if (rsp_tuser !== e.uns)
               report_mismatch($sformatf("unsupported %b want %b", rsp_tuser, e.uns));
            if (rsp_tlast !== e.last)
               report_mismatch($sformatf("last %b want %b", rsp_tlast, e.last));
         end
      end
   end

   // Receiver: random stalls, or a long hold-off to back the queue up.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99, 0) >= receiver_idle_pct);
   end

   initial begin
      int hold_cycles;
      hold_off = 1'b0;
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off = 1'b1;
      for (hold_cycles = 0; hold_cycles < 200; hold_cycles++) @(posedge clock);
      hold_off = 1'b0;
   end

   row_type directed [$];

   task automatic add_row(input func_type fn, input logic [7:0] d, input logic typed,
                          input kind_type k, input logic [4:0] c, input logic u);
      row_type r;
      r.fn = fn; r.byte_in = d; r.typed = typed; r.exp_kind = k; r.exp_cyc = c; r.exp_uns = u;
      directed.push_back(r);
   endtask

   initial begin
      int        n;
      int        wait_cycles;
      logic [7:0] pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = FUNC_START;
      mismatches = 0;
      sender_idle_pct   = 20;
      receiver_idle_pct = 76;
      acc_q = 8'h00; flags_q = 3'b000; pc_q = 16'h0000; sp_q = SP_RESET;
      halted_q = 1'b0; bad_op_count = 32'd0; phase_q = PH_IDLE; op_q = 8'h00; lo_q = 8'h00;
      foreach (gpr_q[i]) gpr_q[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: stray answers, extremes, unknown opcode, CALL/RET, IN.
      add_row(FUNC_MEM,   8'hFF, 1'b0, KIND_DONE,   5'd0, 1'b0); // ignored when idle
      add_row(FUNC_PORT,  8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0); // ignored when idle
      add_row(FUNC_START, 8'hFF, 1'b1, KIND_MEM_RD, 5'd0, 1'b0);
      add_row(FUNC_MEM,   8'h08, 1'b1, KIND_DONE,   5'd4, 1'b1); // unsupported opcode
      add_row(FUNC_START, 8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'h3E, 1'b0, KIND_DONE,   5'd0, 1'b0); // MVI A
      add_row(FUNC_START, 8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0); // busy: ignored
      add_row(FUNC_MEM,   8'hFF, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_START, 8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'hC6, 1'b0, KIND_DONE,   5'd0, 1'b0); // ADI carries out
      add_row(FUNC_MEM,   8'h01, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_START, 8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'hCD, 1'b0, KIND_DONE,   5'd0, 1'b0); // CALL FFFF
      add_row(FUNC_MEM,   8'hFF, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'hFF, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_START, 8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'hC9, 1'b0, KIND_DONE,   5'd0, 1'b0); // RET
      add_row(FUNC_MEM,   8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'h10, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_START, 8'h00, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_MEM,   8'hDB, 1'b0, KIND_DONE,   5'd0, 1'b0); // IN FF
      add_row(FUNC_MEM,   8'hFF, 1'b0, KIND_DONE,   5'd0, 1'b0);
      add_row(FUNC_PORT,  8'h80, 1'b0, KIND_DONE,   5'd0, 1'b0);
      foreach (directed[i]) begin
         send_item(directed[i].fn, directed[i].byte_in);
         if (directed[i].typed && (new_reqs.size() != 1 ||
             new_reqs[0].kind != directed[i].exp_kind || new_reqs[0].cyc != directed[i].exp_cyc ||
             new_reqs[0].uns != directed[i].exp_uns))
            report_mismatch($sformatf("directed row %0d disagrees with its typed answer", i));
      end

      // Random instructions in three idling phases; HLT is kept for the end.
      for (n = 0; n < 130; n++) begin
         if (n == 45) begin sender_idle_pct = 76; receiver_idle_pct = 20; end
         if (n == 90) begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
         case ($urandom_range(9, 0))
            0, 1: pick = 8'h40 | 8'($urandom_range(63, 0));
            2, 3: pick = 8'h80 | 8'($urandom_range(63, 0));
            4:    pick = 8'($urandom_range(255, 0));
            default: begin
               case ($urandom_range(15, 0))
                  0: pick = 8'h01; 1: pick = 8'h21; 2: pick = 8'h31; 3: pick = 8'h32;
                  4: pick = 8'h3A; 5: pick = 8'hC2; 6: pick = 8'hCA; 7: pick = 8'hC3;
                  8: pick = 8'hCD; 9: pick = 8'hC9; 10: pick = 8'hD3; 11: pick = 8'hDB;
                  12: pick = 8'hFE; 13: pick = 8'hD6; 14: pick = 8'h3C; default: pick = 8'h23;
               endcase
            end
         endcase
         if (pick == 8'h76) pick = 8'h3D;
         run_instruction(pick);
      end
      // Halt, then starts answer with a short done item.
      run_instruction(8'h76);
      repeat (4) send_item(FUNC_START, 8'($urandom_range(255, 0)));
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (bus_expected.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && bus_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/i8080s_pkg.sv
rtl/core/i8080s_outq.sv
rtl/core/i8080_subset_core.sv
tb/tb_i8080_subset_core.sv
